// ----- sv/mono_page_framebuffer_defines.svh -----
// Assertion macros for the page-layout mono frame buffer.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef MONO_PAGE_FRAMEBUFFER_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MPF_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mpf assertion failed");
`define MPF_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mpf assertion failed");
`else
`define MPF_ASSERT_IMP(lbl, a, b)
`define MPF_ASSERT_NXT(lbl, a, b)
`endif

`endif

// ----- sv/mpf_pkg.sv -----
// Shared types and constants of the page-layout mono frame buffer.
// Depends on nothing.
package mpf_pkg;

  localparam int SCREEN_W_DEF = 128;
  localparam int SCREEN_H_DEF = 64;
  localparam int CMD_LEN      = 3;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] PIXEL_PATTERN = 8'h80;
  localparam logic [7:0] FULL_BYTE     = 8'hFF;
  localparam logic [3:0] PIXEL_COUNT   = 4'd1;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_FILL   = 2'd1,
    OP_BITMAP = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef struct packed {
    logic       is_command;
    logic [7:0] cmd_byte;
    logic       frame_end;
  } flush_info_t;

endpackage

// ----- sv/mpf_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module mpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/mpf_flush.sv -----
// Panel stream sequencer: page and position counters, command bytes, data address.
// Depends on mpf_pkg and mono_page_framebuffer_defines.svh.
`include "mono_page_framebuffer_defines.svh"

module mpf_flush #(
  parameter int SCREEN_W   = mpf_pkg::SCREEN_W_DEF,
  parameter int PAGE_COUNT = (mpf_pkg::SCREEN_H_DEF + 7) / 8,
  parameter int AW         = $clog2(SCREEN_W * PAGE_COUNT)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  output mpf_pkg::flush_info_t info,
  output logic [AW-1:0]       addr
);

  localparam logic [7:0] POS_LAST  = 8'(SCREEN_W + mpf_pkg::CMD_LEN - 1);
  localparam logic [2:0] PAGE_LAST = 3'(PAGE_COUNT - 1);
  localparam logic [7:0] DATA_OFS  = 8'(mpf_pkg::CMD_LEN);

  logic [2:0] page;
  logic [7:0] pos;
  logic       pos_wrap;
  logic [AW-1:0] page_base;

  assign pos_wrap  = (pos == POS_LAST);
  assign page_base = AW'(page * SCREEN_W);
  assign addr      = page_base + AW'(pos - DATA_OFS);

  always_comb begin
    info.is_command = 1'b1;
    info.frame_end  = 1'b0;
    unique case (pos)
      8'd0:    info.cmd_byte = mpf_pkg::CMD_PAGE_BASE + {5'b0, page};
      8'd1:    info.cmd_byte = mpf_pkg::CMD_COL_LOW;
      8'd2:    info.cmd_byte = mpf_pkg::CMD_COL_HIGH;
      default: begin
        info.cmd_byte   = mpf_pkg::CMD_COL_LOW;
        info.is_command = 1'b0;
        info.frame_end  = pos_wrap && (page == PAGE_LAST);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page <= 3'd0;
      pos  <= 8'd0;
    end else if (advance) begin
      if (pos_wrap) begin
        pos  <= 8'd0;
        page <= (page == PAGE_LAST) ? 3'd0 : page + 3'd1;
      end else begin
        pos <= pos + 8'd1;
      end
    end
  end

  `MPF_ASSERT_IMP(a_pos_range, 1'b1, pos <= POS_LAST && page <= PAGE_LAST)
  `MPF_ASSERT_NXT(a_frame_wrap, advance && info.frame_end, page == 3'd0 && pos == 8'd0)
  `MPF_ASSERT_NXT(a_hold, !advance, $stable(pos) && $stable(page))

endmodule

// ----- sv/mono_page_framebuffer.sv -----
// Top level of the page-layout mono frame buffer: control, read-modify-write, output.
// Depends on mpf_pkg, mpf_ram, mpf_flush and mono_page_framebuffer_defines.svh.
//
// channel | direction | tuser      | tdata (lowest bit up)                        | tlast
// s       | in        | op         | pos_x, pos_y, ink, pattern, bit_count        | -
// m       | out       | is_command | out_byte                                     | frame_end
//
// Pixel and bitmap items do one read-modify-write per column, with read and
// write-back overlapped on the two RAM ports.
// A flush step passes S_FLUSH_RD, then S_FLUSH_OUT with any wait for the output register.
// Fill sweeps the store, one byte a cycle.
// After reset a clearing pass over all SCREEN_W * pages bytes (1024 by default)
// runs before the first item is taken.
`include "mono_page_framebuffer_defines.svh"

module mono_page_framebuffer #(
  parameter int SCREEN_W = mpf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = mpf_pkg::SCREEN_H_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // pos_x[7:0], pos_y[15:8], ink[16], pattern[24:17],
                                // bit_count[28:25], zero[31:29]
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte[7:0]
  output logic        m_tuser,  // is_command[0]
  output logic        m_tlast
);

  localparam int PAGE_COUNT = (SCREEN_H + 7) / 8;
  localparam int STORE_SIZE = SCREEN_W * PAGE_COUNT;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(STORE_SIZE - 1);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DRAW,
    S_FLUSH_RD,
    S_FLUSH_OUT
  } state_t;

  state_t      state;
  logic [AW-1:0] sweep_addr;
  logic        fill_val;
  logic [3:0]  step;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic        ink_q;
  logic [7:0]  pat_q;
  logic [3:0]  cnt_q;
  logic        p_en;
  logic [AW-1:0] p_addr;

  logic        accept;
  logic        slot_free;
  logic [8:0]  col;
  logic        bit_en;
  logic [7:0]  mask;
  logic [AW-1:0] draw_addr;
  logic        flush_adv;
  logic [AW-1:0] flush_addr;
  mpf_pkg::flush_info_t flush_info;

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign flush_adv = (state == S_FLUSH_OUT) && slot_free;

  assign col       = {1'b0, x_q} + {5'b0, step};
  assign mask      = 8'(1) << y_q[2:0];
  assign draw_addr = AW'(y_q[7:3] * SCREEN_W) + AW'(col);
  assign bit_en    = (state == S_DRAW) && !step[3] && pat_q[7] && (step < cnt_q)
                     && (col < 9'(SCREEN_W)) && (y_q < 8'(SCREEN_H));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_addr;
    ram_wdata = ink_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
    ram_re    = 1'b0;
    ram_raddr = draw_addr;
    unique case (state)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = {8{fill_val}};
      end
      S_DRAW: begin
        ram_we = p_en;
        ram_re = bit_en;
      end
      S_FLUSH_RD: begin
        ram_re    = !flush_info.is_command;
        ram_raddr = flush_addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      fill_val   <= 1'b0;
      step       <= 4'd0;
      p_en       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (flush_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == SWEEP_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_q   <= s_tdata[7:0];
            y_q   <= s_tdata[15:8];
            ink_q <= s_tdata[16];
            step  <= 4'd0;
            p_en  <= 1'b0;
            unique case (mpf_pkg::op_t'(s_tuser))
              mpf_pkg::OP_PIXEL: begin
                pat_q <= mpf_pkg::PIXEL_PATTERN;
                cnt_q <= mpf_pkg::PIXEL_COUNT;
                state <= S_DRAW;
              end
              mpf_pkg::OP_BITMAP: begin
                pat_q <= s_tdata[24:17];
                cnt_q <= s_tdata[28:25];
                state <= S_DRAW;
              end
              mpf_pkg::OP_FILL: begin
                fill_val   <= s_tdata[16];
                sweep_addr <= '0;
                state      <= S_SWEEP;
              end
              mpf_pkg::OP_FLUSH: begin
                state <= S_FLUSH_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DRAW: begin
          p_en   <= bit_en;
          p_addr <= draw_addr;
          pat_q  <= {pat_q[6:0], 1'b0};
          step   <= step + 4'd1;
          if (step[3]) begin
            state <= S_IDLE;
          end
        end
        S_FLUSH_RD: begin
          state <= S_FLUSH_OUT;
        end
        S_FLUSH_OUT: begin
          if (slot_free) begin
            m_tdata  <= flush_info.is_command ? flush_info.cmd_byte : ram_rdata;
            m_tuser  <= flush_info.is_command;
            m_tlast  <= flush_info.frame_end;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mpf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpf_flush #(
    .SCREEN_W  (SCREEN_W),
    .PAGE_COUNT(PAGE_COUNT),
    .AW        (AW)
  ) u_flush (
    .clk    (clk),
    .rst    (rst),
    .advance(flush_adv),
    .info   (flush_info),
    .addr   (flush_addr)
  );

  `MPF_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
  `MPF_ASSERT_IMP(a_idle_no_write, state == S_IDLE, !ram_we)
  `MPF_ASSERT_NXT(a_flush_out, flush_adv, m_tvalid && state == S_IDLE)
  `MPF_ASSERT_IMP(a_last_is_data, m_tvalid && m_tlast, !m_tuser)

endmodule
